>>> sv/itef_pkg.sv
// itef_pkg: shared types, widths and constants of the inductor track error front end
// no dependencies; every other file refers to it by scoped names
`default_nettype none
package itef_pkg;

	// fixed field widths
	localparam int SAMPLE_BITS = 12;
	localparam int CHANNELS    = 10;
	localparam int USED        = 8;
	localparam int CFGW        = 7;
	localparam int OPW         = 2;
	localparam int ERRW        = 16;
	localparam int MINW        = 13;
	localparam int CFG_IDXW    = 1;

	// q8 fixed point
	localparam int Q8_BITS     = 8;
	localparam int Q8_ONE      = 256;
	localparam int NORM_SCALE  = 100;
	localparam int NORM_MULT   = NORM_SCALE * Q8_ONE;

	// derived datapath widths
	localparam int NORMW = SAMPLE_BITS + 15;          // normalized channel value
	localparam int LW    = NORMW + 1;                 // row sum or row root
	localparam int MAGW  = CFGW + LW - Q8_BITS;       // gain times |difference|
	localparam int DNW   = MAGW + Q8_BITS;            // divider dividend
	localparam int DDW   = LW + 1 - Q8_BITS;          // divider divisor
	localparam int SQW   = 2 * NORMW + 1;             // sum of two squares

	localparam logic [MINW-1:0]        CAL_MIN_START = MINW'(5000);
	localparam logic [SAMPLE_BITS-1:0] FULL_SCALE    = '1;

	// register reset values
	localparam logic [CFGW-1:0] AVG_COUNT_RESET = CFGW'(10);
	localparam logic [CFGW-1:0] GAIN_RESET      = CFGW'(30);

	// register indexes
	localparam logic [CFG_IDXW-1:0] CFG_AVG_COUNT = 1'b0;
	localparam logic [CFG_IDXW-1:0] CFG_GAIN      = 1'b1;

	typedef enum logic [OPW-1:0] {
		OP_SWEEP     = 2'd0,
		OP_CAL_START = 2'd1,
		OP_CAL_END   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		DV_AVG,
		DV_NORM,
		DV_ERR
	} div_src_t;

	// controller to datapath
	typedef struct packed {
		logic       sweep;
		logic       cal_start;
		logic       cal_end;
		logic       div_go;
		div_src_t   div_src;
		logic       cal_upd;
		logic       sq_go;
		logic       root_go;
		logic       err_prep;
		logic       out_load;
		logic [3:0] idx;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic win_close;
		logic div_done;
		logic root_done;
		logic fault;
		logic cal_mode;
		logic out_free;
	} sts_t;

	// normalized slot to channel: right outer, right inner, left inner, left outer per row
	function automatic logic [3:0] used_ch(input logic [2:0] slot);
		logic [3:0] ch;
		case (slot)
			3'd0:    ch = 4'd0;
			3'd1:    ch = 4'd1;
			3'd2:    ch = 4'd3;
			3'd3:    ch = 4'd4;
			3'd4:    ch = 4'd5;
			3'd5:    ch = 4'd6;
			3'd6:    ch = 4'd8;
			default: ch = 4'd9;
		endcase
		return ch;
	endfunction

endpackage
`default_nettype wire

>>> sv/itef_if.sv
// itef_in_if and itef_out_if: valid/ready channels for sweep items and result items
// depends on itef_pkg for field widths
`default_nettype none
interface itef_in_if;
	logic                             valid;
	logic                             ready;
	logic [itef_pkg::OPW-1:0]         operation;
	logic [itef_pkg::SAMPLE_BITS-1:0] sample_ch1;
	logic [itef_pkg::SAMPLE_BITS-1:0] sample_ch2;
	logic [itef_pkg::SAMPLE_BITS-1:0] sample_ch3;
	logic [itef_pkg::SAMPLE_BITS-1:0] sample_ch4;
	logic [itef_pkg::SAMPLE_BITS-1:0] sample_ch5;
	logic [itef_pkg::SAMPLE_BITS-1:0] sample_ch6;
	logic [itef_pkg::SAMPLE_BITS-1:0] sample_ch7;
	logic [itef_pkg::SAMPLE_BITS-1:0] sample_ch8;
	logic [itef_pkg::SAMPLE_BITS-1:0] sample_ch9;
	logic [itef_pkg::SAMPLE_BITS-1:0] sample_ch10;

	modport source (output valid, operation, sample_ch1, sample_ch2, sample_ch3, sample_ch4,
		sample_ch5, sample_ch6, sample_ch7, sample_ch8, sample_ch9, sample_ch10,
		input ready);
	modport sink (input valid, operation, sample_ch1, sample_ch2, sample_ch3, sample_ch4,
		sample_ch5, sample_ch6, sample_ch7, sample_ch8, sample_ch9, sample_ch10,
		output ready);
endinterface

interface itef_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [itef_pkg::ERRW-1:0] forward_error;
	logic signed [itef_pkg::ERRW-1:0] turn_error;
	logic                             range_fault;
	logic                             calibrating;

	modport source (output valid, forward_error, turn_error, range_fault, calibrating,
		input ready);
	modport sink (input valid, forward_error, turn_error, range_fault, calibrating,
		output ready);
endinterface
`default_nettype wire

>>> sv/itef_div.sv
// itef_div: restoring divider, one quotient bit per cycle
// depends on itef_pkg for dividend and divisor widths
`default_nettype none
module itef_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [itef_pkg::DNW-1:0] num,
	input  wire logic [itef_pkg::DDW-1:0] den,
	output logic                          done,
	output logic [itef_pkg::DNW-1:0]      quot
);
	localparam int NW = itef_pkg::DNW;
	localparam int DW = itef_pkg::DDW;
	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] quo_q;
	logic [DW:0]   trial;
	logic          take;

	// shift in the next dividend bit and try the subtract
	assign trial = {rem_q, quo_q[NW-1]};
	assign take  = trial >= {1'b0, den_q};
	assign quot  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], take};
		end
	end
endmodule
`default_nettype wire

>>> sv/itef_sqrt.sv
// itef_sqrt: digit by digit integer square root, one root bit per cycle
// depends on itef_pkg for radicand and root widths
`default_nettype none
module itef_sqrt (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [itef_pkg::SQW-1:0] rad,
	output logic                          done,
	output logic [itef_pkg::LW-1:0]       root
);
	localparam int RW  = itef_pkg::LW;
	localparam int RMW = RW + 2;
	localparam int CW  = $clog2(RW + 1);

	logic           busy_q;
	logic [CW-1:0]  cnt_q;
	logic [2*RW-1:0] rad_q;
	logic [RW-1:0]  root_q;
	logic [RMW-1:0] rem_q;
	logic [RMW+1:0] cur;
	logic [RMW+1:0] trial;
	logic           take;

	// bring down two radicand bits, trial divisor is 4*root+1
	assign cur   = {rem_q, rad_q[2*RW-1 -: 2]};
	assign trial = (RMW + 2)'({root_q, 2'b01});
	assign take  = cur >= trial;
	assign root  = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= (2 * RW)'(rad);
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[2*RW-3:0], 2'b00};
			rem_q  <= take ? RMW'(cur - trial) : RMW'(cur);
			root_q <= {root_q[RW-2:0], take};
		end
	end
endmodule
`default_nettype wire

>>> sv/itef_dp.sv
// itef_dp: datapath with sums, averages, calibration bounds, normalizer, roots and errors
// depends on itef_pkg, itef_div and itef_sqrt
`default_nettype none
module itef_dp #(
	parameter int MAX_AVERAGE = 64
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire itef_pkg::cmd_t                   cmd,
	input  wire logic [itef_pkg::SAMPLE_BITS-1:0] sample [itef_pkg::CHANNELS],
	input  wire logic [itef_pkg::CFGW-1:0]        avg_count,
	input  wire logic [itef_pkg::CFGW-1:0]        gain,
	input  wire logic                             out_ready,
	output itef_pkg::sts_t                        sts,
	output logic                                  out_valid,
	output logic signed [itef_pkg::ERRW-1:0]      forward_error,
	output logic signed [itef_pkg::ERRW-1:0]      turn_error,
	output logic                                  range_fault,
	output logic                                  calibrating
);
	localparam int SB    = itef_pkg::SAMPLE_BITS;
	localparam int CH    = itef_pkg::CHANNELS;
	localparam int CNTW  = $clog2(MAX_AVERAGE + 1);
	localparam int SUMW  = SB + CNTW;
	localparam int CMPW  = (CNTW > itef_pkg::CFGW) ? CNTW : itef_pkg::CFGW;
	localparam int NORMW = itef_pkg::NORMW;
	localparam int LW    = itef_pkg::LW;
	localparam int DNW   = itef_pkg::DNW;
	localparam int DDW   = itef_pkg::DDW;
	localparam int MAGW  = itef_pkg::MAGW;
	localparam int SQW   = itef_pkg::SQW;
	localparam int ERRW  = itef_pkg::ERRW;
	localparam int MINW  = itef_pkg::MINW;
	localparam int QB    = itef_pkg::Q8_BITS;

	logic [SUMW-1:0]   sum_q  [CH];
	logic [SB-1:0]     avg_q  [CH];
	logic [MINW-1:0]   min_q  [CH];
	logic [SB-1:0]     max_q  [CH];
	logic [NORMW-1:0]  norm_q [itef_pkg::USED];
	logic [LW-1:0]     root_q [2];
	logic [ERRW-1:0]   err_q  [2];
	logic [CNTW-1:0]   cnt_q;
	logic [CNTW-1:0]   taken_q;
	logic              cal_mode_q;
	logic              out_valid_q;
	logic [2*NORMW-1:0] sq_a_s1;
	logic [2*NORMW-1:0] sq_b_s1;
	logic              root_side_q;
	logic [MAGW-1:0]   mag_q;
	logic [DDW-1:0]    s_q;
	logic              d_neg_q;
	logic              d_ok_q;
	itef_pkg::div_src_t dst_src_q;
	logic [3:0]        dst_idx_q;

	logic [CMPW-1:0]   cnt_cfg;
	logic [CNTW-1:0]   want;
	logic [CNTW-1:0]   taken;
	logic              fault;
	logic [DNW-1:0]    div_num;
	logic [DDW-1:0]    div_den;
	logic              div_done;
	logic [DNW-1:0]    div_quot;
	logic              root_done;
	logic [LW-1:0]     root_val;
	logic [SQW-1:0]    rad;
	logic [3:0]        nch;
	logic [SB-1:0]     n_avg;
	logic [MINW-1:0]   n_lo;
	logic [SB-1:0]     n_hi;
	logic [LW-1:0]     el;
	logic [LW-1:0]     er;
	logic [LW-1:0]     ediff;
	logic [LW:0]       esum;
	logic [ERRW-1:0]   q16;

	// window length: zero means one, saturate at the deepest window
	always_comb begin
		cnt_cfg = CMPW'(avg_count);
		if (cnt_cfg == '0)
			want = CNTW'(1);
		else if (cnt_cfg > CMPW'(MAX_AVERAGE))
			want = CNTW'(MAX_AVERAGE);
		else
			want = CNTW'(cnt_cfg);
	end
	assign taken = cnt_q + 1'b1;

	// some used channel has an empty range
	always_comb begin
		fault = 1'b0;
		for (int k = 0; k < itef_pkg::USED; k++) begin
			if ({1'b0, max_q[itef_pkg::used_ch(3'(k))]} <= min_q[itef_pkg::used_ch(3'(k))])
				fault = 1'b1;
		end
	end

	// normalizer operands for the selected slot
	assign nch   = itef_pkg::used_ch(cmd.idx[2:0]);
	assign n_avg = avg_q[nch];
	assign n_lo  = min_q[nch];
	assign n_hi  = max_q[nch];

	// divider operand select
	always_comb begin
		case (cmd.div_src)
			itef_pkg::DV_AVG: begin
				div_num = DNW'(sum_q[cmd.idx]);
				div_den = DDW'(taken_q);
			end
			itef_pkg::DV_NORM: begin
				div_num = ({1'b0, n_avg} > n_lo)
					? DNW'(SB'(n_avg - n_lo[SB-1:0])) * DNW'(itef_pkg::NORM_MULT) : '0;
				div_den = DDW'(SB'(n_hi - n_lo[SB-1:0]));
			end
			default: begin
				div_num = d_ok_q ? {mag_q, {QB{1'b0}}} : '0;
				div_den = d_ok_q ? s_q : DDW'(1);
			end
		endcase
	end

	itef_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_go),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign rad = SQW'(sq_a_s1) + SQW'(sq_b_s1);

	itef_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.root_go),
		.rad    (rad),
		.done   (root_done),
		.root   (root_val)
	);

	// row pair for the error being prepared: forward from sums, turn from roots
	always_comb begin
		if (cmd.idx[0]) begin
			el = root_q[0];
			er = root_q[1];
		end else begin
			el = LW'(norm_q[3]) + LW'(norm_q[2]);
			er = LW'(norm_q[0]) + LW'(norm_q[1]);
		end
		ediff = (el >= er) ? el - er : er - el;
		esum  = (LW + 1)'(el) + (LW + 1)'(er);
	end

	assign q16 = div_quot[ERRW-1:0];

	// control state: sums, window count, calibration bounds, mode, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CH; c++) begin
				sum_q[c] <= '0;
				min_q[c] <= '0;
				max_q[c] <= itef_pkg::FULL_SCALE;
			end
			cnt_q       <= '0;
			taken_q     <= '0;
			cal_mode_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// accumulate a sweep
			if (cmd.sweep) begin
				for (int c = 0; c < CH; c++)
					sum_q[c] <= sum_q[c] + SUMW'(sample[c]);
				if (taken >= want) begin
					cnt_q   <= '0;
					taken_q <= taken;
				end else begin
					cnt_q <= taken;
				end
			end
			// sum is consumed once its division starts
			if (cmd.div_go && cmd.div_src == itef_pkg::DV_AVG)
				sum_q[cmd.idx] <= '0;
			if (cmd.cal_start) begin
				for (int c = 0; c < CH; c++) begin
					max_q[c] <= '0;
					min_q[c] <= itef_pkg::CAL_MIN_START;
				end
				cal_mode_q <= 1'b1;
			end
			if (cmd.cal_end)
				cal_mode_q <= 1'b0;
			// widen bounds with this window's averages
			if (cmd.cal_upd && cal_mode_q) begin
				for (int c = 0; c < CH; c++) begin
					if (avg_q[c] > max_q[c])
						max_q[c] <= avg_q[c];
					if ({1'b0, avg_q[c]} < min_q[c])
						min_q[c] <= MINW'(avg_q[c]);
				end
			end
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.div_go) begin
			dst_src_q <= cmd.div_src;
			dst_idx_q <= cmd.idx;
		end
		if (div_done) begin
			case (dst_src_q)
				itef_pkg::DV_AVG:  avg_q[dst_idx_q] <= div_quot[SB-1:0];
				itef_pkg::DV_NORM: norm_q[dst_idx_q[2:0]] <= div_quot[NORMW-1:0];
				default:           err_q[dst_idx_q[0]] <= d_neg_q ? ~q16 + 1'b1 : q16;
			endcase
		end
		// squares of one turn pair: left is ch10/ch9, right is ch6/ch7
		if (cmd.sq_go) begin
			if (cmd.idx[0]) begin
				sq_a_s1 <= (2 * NORMW)'(norm_q[4]) * (2 * NORMW)'(norm_q[4]);
				sq_b_s1 <= (2 * NORMW)'(norm_q[5]) * (2 * NORMW)'(norm_q[5]);
			end else begin
				sq_a_s1 <= (2 * NORMW)'(norm_q[7]) * (2 * NORMW)'(norm_q[7]);
				sq_b_s1 <= (2 * NORMW)'(norm_q[6]) * (2 * NORMW)'(norm_q[6]);
			end
		end
		if (cmd.root_go)
			root_side_q <= cmd.idx[0];
		if (root_done)
			root_q[root_side_q] <= root_val;
		// difference over sum operands
		if (cmd.err_prep) begin
			d_ok_q  <= (el > LW'(itef_pkg::Q8_ONE)) || (er > LW'(itef_pkg::Q8_ONE));
			d_neg_q <= el < er;
			mag_q   <= MAGW'(gain) * MAGW'(ediff[LW-1:QB]);
			s_q     <= esum[LW:QB];
		end
		if (cmd.out_load) begin
			forward_error <= (cal_mode_q || fault) ? '0 : err_q[0];
			turn_error    <= (cal_mode_q || fault) ? '0 : err_q[1];
			range_fault   <= fault;
			calibrating   <= cal_mode_q;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts.win_close = taken >= want;
		sts.div_done  = div_done;
		sts.root_done = root_done;
		sts.fault     = fault;
		sts.cal_mode  = cal_mode_q;
		sts.out_free  = !out_valid_q || out_ready;
	end
endmodule
`default_nettype wire

>>> sv/itef_ctrl.sv
// itef_ctrl: sequencer for accumulation, window close, calibration and error forming
// depends on itef_pkg for command and status structs
`default_nettype none
module itef_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	input  wire logic [itef_pkg::OPW-1:0] operation,
	input  wire itef_pkg::sts_t           sts,
	output logic                          in_ready,
	output itef_pkg::cmd_t                cmd
);
	typedef enum logic [3:0] {
		S_IDLE,
		S_AVG_GO,
		S_AVG_WAIT,
		S_CAL,
		S_CHECK,
		S_NORM_GO,
		S_NORM_WAIT,
		S_SQ,
		S_ROOT_GO,
		S_ROOT_WAIT,
		S_ERR_PREP,
		S_ERR_GO,
		S_ERR_WAIT,
		S_OUT
	} state_t;

	state_t     state_q;
	logic [3:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && operation == itef_pkg::OP_SWEEP && sts.win_close) begin
						state_q <= S_AVG_GO;
						idx_q   <= '0;
					end
				end
				S_AVG_GO: state_q <= S_AVG_WAIT;
				S_AVG_WAIT: begin
					if (sts.div_done) begin
						if (idx_q == 4'(itef_pkg::CHANNELS - 1)) begin
							state_q <= S_CAL;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_AVG_GO;
						end
					end
				end
				S_CAL: state_q <= S_CHECK;
				S_CHECK: begin
					idx_q <= '0;
					if (sts.cal_mode || sts.fault)
						state_q <= S_OUT;
					else
						state_q <= S_NORM_GO;
				end
				S_NORM_GO: state_q <= S_NORM_WAIT;
				S_NORM_WAIT: begin
					if (sts.div_done) begin
						if (idx_q == 4'(itef_pkg::USED - 1)) begin
							idx_q   <= '0;
							state_q <= S_SQ;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_NORM_GO;
						end
					end
				end
				S_SQ:      state_q <= S_ROOT_GO;
				S_ROOT_GO: state_q <= S_ROOT_WAIT;
				S_ROOT_WAIT: begin
					if (sts.root_done) begin
						if (idx_q[0]) begin
							idx_q   <= '0;
							state_q <= S_ERR_PREP;
						end else begin
							idx_q   <= 4'd1;
							state_q <= S_SQ;
						end
					end
				end
				S_ERR_PREP: state_q <= S_ERR_GO;
				S_ERR_GO:   state_q <= S_ERR_WAIT;
				S_ERR_WAIT: begin
					if (sts.div_done) begin
						if (idx_q[0]) begin
							state_q <= S_OUT;
						end else begin
							idx_q   <= 4'd1;
							state_q <= S_ERR_PREP;
						end
					end
				end
				S_OUT: begin
					if (sts.out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = state_q == S_IDLE;

	// commands decoded from state
	always_comb begin
		cmd           = '0;
		cmd.idx       = idx_q;
		cmd.div_src   = itef_pkg::DV_AVG;
		if (state_q == S_IDLE && in_valid) begin
			case (operation)
				itef_pkg::OP_SWEEP:     cmd.sweep     = 1'b1;
				itef_pkg::OP_CAL_START: cmd.cal_start = 1'b1;
				itef_pkg::OP_CAL_END:   cmd.cal_end   = 1'b1;
				default: ;
			endcase
		end
		case (state_q)
			S_AVG_GO: cmd.div_go = 1'b1;
			S_CAL:    cmd.cal_upd = 1'b1;
			S_NORM_GO, S_NORM_WAIT: begin
				cmd.div_src = itef_pkg::DV_NORM;
				cmd.div_go  = state_q == S_NORM_GO;
			end
			S_SQ:       cmd.sq_go    = 1'b1;
			S_ROOT_GO:  cmd.root_go  = 1'b1;
			S_ERR_PREP: cmd.err_prep = 1'b1;
			S_ERR_GO, S_ERR_WAIT: begin
				cmd.div_src = itef_pkg::DV_ERR;
				cmd.div_go  = state_q == S_ERR_GO;
			end
			S_OUT:    cmd.out_load = sts.out_free;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

>>> sv/inductor_track_error_frontend_top.sv
// inductor_track_error_frontend_top: sweep averaging, calibration and track error forming
// depends on itef_pkg, itef_if, itef_ctrl and itef_dp
//
// channel  dir  handshake       payload
// sweep    in   valid/ready     operation, sample_ch1..sample_ch10
// result   out  valid/ready     forward_error, turn_error, range_fault, calibrating
// cfg      in   cfg_wr_en       cfg_index, cfg_data (averaging_count, error_gain)
//
// a sweep, start or end item is taken whenever the sequencer is idle; a sweep that
// closes a window starts the work, during which sweep.ready is low: ten averaging
// divisions, then eight normalizing divisions, two 28-step roots and two error
// divisions, all divisions on the shared 35-step divider; only the averaging
// divisions run when calibrating or faulted. the result register frees the input
// side while a result waits; reset is asynchronous and loads the full-scale bounds
// and register defaults
`default_nettype none
module inductor_track_error_frontend_top #(
	parameter int MAX_AVERAGE = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	itef_in_if.sink                             sweep,
	itef_out_if.source                          result,
	input  wire logic                           cfg_wr_en,
	input  wire logic [itef_pkg::CFG_IDXW-1:0]  cfg_index,
	input  wire logic [itef_pkg::CFGW-1:0]      cfg_data
);
	logic [itef_pkg::CFGW-1:0]        avg_count_q;
	logic [itef_pkg::CFGW-1:0]        gain_q;
	logic [itef_pkg::SAMPLE_BITS-1:0] sample [itef_pkg::CHANNELS];
	itef_pkg::cmd_t                   cmd;
	itef_pkg::sts_t                   sts;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_count_q <= itef_pkg::AVG_COUNT_RESET;
			gain_q      <= itef_pkg::GAIN_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				itef_pkg::CFG_AVG_COUNT: avg_count_q <= cfg_data;
				itef_pkg::CFG_GAIN:      gain_q      <= cfg_data;
			endcase
		end
	end

	// gather the sweep into a channel array
	assign sample[0] = sweep.sample_ch1;
	assign sample[1] = sweep.sample_ch2;
	assign sample[2] = sweep.sample_ch3;
	assign sample[3] = sweep.sample_ch4;
	assign sample[4] = sweep.sample_ch5;
	assign sample[5] = sweep.sample_ch6;
	assign sample[6] = sweep.sample_ch7;
	assign sample[7] = sweep.sample_ch8;
	assign sample[8] = sweep.sample_ch9;
	assign sample[9] = sweep.sample_ch10;

	itef_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sweep.valid),
		.operation (sweep.operation),
		.sts       (sts),
		.in_ready  (sweep.ready),
		.cmd       (cmd)
	);

	itef_dp #(
		.MAX_AVERAGE (MAX_AVERAGE)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sample        (sample),
		.avg_count     (avg_count_q),
		.gain          (gain_q),
		.out_ready     (result.ready),
		.sts           (sts),
		.out_valid     (result.valid),
		.forward_error (result.forward_error),
		.turn_error    (result.turn_error),
		.range_fault   (result.range_fault),
		.calibrating   (result.calibrating)
	);
endmodule
`default_nettype wire
